### design/itp_pkg.sv
`timescale 1ns / 1ps
// shared types, character codes and helpers for the infix to postfix converter
package itp_pkg;

  // stack depth default
  localparam int STACK_DEPTH_DEF = 32;

  // character codes
  localparam logic [7:0] CH_POW   = 8'h5E;  // '^'
  localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] CH_ADD   = 8'h2B;  // '+'
  localparam logic [7:0] CH_SUB   = 8'h2D;  // '-'
  localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNMATCHED = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_PUSH,
    S_FIN
  } state_t;

  // what the pop loop is working for
  typedef enum logic [1:0] {
    M_PAREN,
    M_OP,
    M_FLUSH
  } mode_t;

  // rank with the unranked case mapped to zero, order kept
  function automatic logic [1:0] rank_of(logic [7:0] c);
    logic [1:0] r;
    r = 2'd0;
    if (c == CH_POW) r = 2'd3;
    else if (c == CH_MUL || c == CH_DIV) r = 2'd2;
    else if (c == CH_ADD || c == CH_SUB) r = 2'd1;
    return r;
  endfunction

  // ascii digits and letters
  function automatic logic is_alnum(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

### design/itp_expr_if.sv
`timescale 1ns / 1ps
// input channel: one infix character a word
interface itp_expr_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       expr_end;

  modport source (output valid, output ch, output expr_end, input ready);
  modport sink   (input valid, input ch, input expr_end, output ready);
endinterface

### design/itp_postfix_if.sv
`timescale 1ns / 1ps
// output channel: one postfix character a word
interface itp_postfix_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic [1:0] status;

  modport source (output valid, output out_char, output run_last, output status, input ready);
  modport sink   (input valid, input out_char, input run_last, input status, output ready);
endinterface

### design/infix_to_postfix_converter_top.sv
`timescale 1ns / 1ps
// Shunting-yard infix to postfix converter. Characters enter one word at a time on expr,
// postfix words leave on postfix, with run_last on the final word caused by each input
// word and status flagging a dropped character (stack overflow, unmatched ')'). The
// operator stack sits in a single-port-style synchronous memory of STACK_DEPTH entries.
// One input word is worked on at a time. A letter, digit or unmatched ')' is accepted and
// then its held word is released, and a '(' has a push step between the two. Every stack
// entry examined takes a memory read, then a compare and pop: a matched ')' examines
// entries down to the discarded '(', and an operator examines entries until one stops
// the pops or the stack is empty, then pushes. With expr_end set the flush then reads and
// pops every stack entry. A result that finds the pending and output words both held while
// postfix.ready is low stalls until the output drains. Each result is held in a pending
// register so that run_last is known when it is handed to the output register; the output
// register lets a new input word be taken while a word waits.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  itp_expr_if.sink    expr,
  itp_postfix_if.source postfix
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // operator stack
  logic [7:0]    stack_mem [STACK_DEPTH];
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // control registers
  itp_pkg::state_t state, state_next;
  itp_pkg::mode_t  mode, mode_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   open_count, open_count_next;
  logic [7:0]      cur_char;
  logic            cur_last;

  // pending and output words
  logic            p_valid;
  logic [7:0]      p_char;
  itp_pkg::status_t p_status;
  logic            o_valid;
  logic [7:0]      o_char;
  logic            o_last;
  itp_pkg::status_t o_status;

  // generator controls
  logic            gen_valid;
  logic [7:0]      gen_char;
  itp_pkg::status_t gen_status;
  logic            fin_release;
  logic            out_free;
  logic            emit_ok;
  logic            last_v;
  logic [CW-1:0]   count_dec;
  logic            stop_op;
  logic            stack_full;

  assign out_free   = !o_valid || postfix.ready;
  assign emit_ok    = !p_valid || out_free;
  assign count_dec  = count - CW'(1);
  assign stack_full = (count >= CW'(STACK_DEPTH));
  assign wr_addr    = count[AW-1:0];
  assign rd_addr    = count_dec[AW-1:0];

  // operator pops: '^' pops only strictly higher rank
  always_comb begin
    if (rd_data == itp_pkg::CH_OPEN) begin
      stop_op = 1'b1;
    end else if (cur_char == itp_pkg::CH_POW) begin
      stop_op = itp_pkg::rank_of(rd_data) <= itp_pkg::rank_of(cur_char);
    end else begin
      stop_op = itp_pkg::rank_of(rd_data) < itp_pkg::rank_of(cur_char);
    end
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= cur_char;
    end
    if (rd_en) begin
      rd_data <= stack_mem[rd_addr];
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= itp_pkg::S_IDLE;
      mode       <= itp_pkg::M_FLUSH;
      count      <= '0;
      open_count <= '0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      count      <= count_next;
      open_count <= open_count_next;
    end
  end

  // latched input word
  always_ff @(posedge clk) begin
    if (state == itp_pkg::S_IDLE && expr.valid) begin
      cur_char <= expr.ch;
      cur_last <= expr.expr_end;
    end
  end

  // next state, stack updates and result generation
  always_comb begin
    state_next      = state;
    mode_next       = mode;
    count_next      = count;
    open_count_next = open_count;
    gen_valid       = 1'b0;
    gen_char        = rd_data;
    gen_status      = itp_pkg::ST_OK;
    fin_release     = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    last_v          = (state == itp_pkg::S_IDLE) ? expr.expr_end : cur_last;
    expr.ready      = (state == itp_pkg::S_IDLE);

    unique case (state)
      itp_pkg::S_IDLE: begin
        if (expr.valid) begin
          state_next = last_v ? itp_pkg::S_RD : itp_pkg::S_FIN;
          if (last_v) mode_next = itp_pkg::M_FLUSH;
          gen_char = expr.ch;
          if (itp_pkg::is_alnum(expr.ch)) begin
            gen_valid = 1'b1;
          end else if (expr.ch == itp_pkg::CH_OPEN) begin
            state_next = itp_pkg::S_PUSH;
          end else if (expr.ch == itp_pkg::CH_CLOSE) begin
            if (open_count == '0) begin
              gen_valid  = 1'b1;
              gen_status = itp_pkg::ST_UNMATCHED;
            end else begin
              mode_next  = itp_pkg::M_PAREN;
              state_next = itp_pkg::S_RD;
            end
          end else begin
            mode_next  = itp_pkg::M_OP;
            state_next = itp_pkg::S_RD;
          end
        end
      end

      itp_pkg::S_RD: begin
        if (count == '0) begin
          if (mode == itp_pkg::M_OP) begin
            state_next = itp_pkg::S_PUSH;
          end else if (mode == itp_pkg::M_PAREN && last_v) begin
            mode_next  = itp_pkg::M_FLUSH;
            state_next = itp_pkg::S_RD;
          end else begin
            state_next = itp_pkg::S_FIN;
          end
        end else begin
          rd_en      = 1'b1;
          state_next = itp_pkg::S_CHK;
        end
      end

      itp_pkg::S_CHK: begin
        if (mode == itp_pkg::M_PAREN && rd_data == itp_pkg::CH_OPEN) begin
          // matching '(' is discarded
          count_next      = count_dec;
          open_count_next = open_count - CW'(1);
          if (last_v) begin
            mode_next  = itp_pkg::M_FLUSH;
            state_next = itp_pkg::S_RD;
          end else begin
            state_next = itp_pkg::S_FIN;
          end
        end else if (mode == itp_pkg::M_OP && stop_op) begin
          state_next = itp_pkg::S_PUSH;
        end else if (emit_ok) begin
          gen_valid  = 1'b1;
          count_next = count_dec;
          if (rd_data == itp_pkg::CH_OPEN) open_count_next = open_count - CW'(1);
          state_next = itp_pkg::S_RD;
        end
      end

      itp_pkg::S_PUSH: begin
        gen_char = cur_char;
        if (!stack_full) begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
          if (cur_char == itp_pkg::CH_OPEN) open_count_next = open_count + CW'(1);
          mode_next  = itp_pkg::M_FLUSH;
          state_next = last_v ? itp_pkg::S_RD : itp_pkg::S_FIN;
        end else if (emit_ok) begin
          gen_valid  = 1'b1;
          gen_status = itp_pkg::ST_OVERFLOW;
          mode_next  = itp_pkg::M_FLUSH;
          state_next = last_v ? itp_pkg::S_RD : itp_pkg::S_FIN;
        end
      end

      itp_pkg::S_FIN: begin
        if (!p_valid) begin
          state_next = itp_pkg::S_IDLE;
        end else if (out_free) begin
          fin_release = 1'b1;
          state_next  = itp_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = itp_pkg::S_IDLE;
      end
    endcase
  end

  // pending word and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (postfix.ready) o_valid <= 1'b0;
      if (gen_valid) begin
        if (p_valid) begin
          o_valid  <= 1'b1;
          o_char   <= p_char;
          o_status <= p_status;
          o_last   <= 1'b0;
        end
        p_valid  <= 1'b1;
        p_char   <= gen_char;
        p_status <= gen_status;
      end else if (fin_release) begin
        o_valid  <= 1'b1;
        o_char   <= p_char;
        o_status <= p_status;
        o_last   <= 1'b1;
        p_valid  <= 1'b0;
      end
    end
  end

  assign postfix.valid    = o_valid;
  assign postfix.out_char = o_char;
  assign postfix.run_last = o_last;
  assign postfix.status   = o_status;

endmodule

### tb/itp_postfix_checker.sv
`timescale 1ns / 1ps
// checker for the infix to postfix converter: predicts postfix words and compares them
module itp_postfix_checker #(
  parameter int DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  itp_expr_if    expr,
  itp_postfix_if postfix,
  output int     fail_count,
  output int     words_waiting,
  output int     words_checked,
  output int     overflow_seen,
  output int     unmatched_seen
);

  typedef struct packed {
    logic [7:0]       out_char;
    logic             run_last;
    itp_pkg::status_t status;
  } pf_word_t;

  // predicted operator stack and the postfix words still to come
  logic [7:0] op_stk [DEPTH];
  int         stk_n;
  pf_word_t   postfix_due [$];

  int n_fail      = 0;
  int n_checked   = 0;
  int n_overflow  = 0;
  int n_unmatched = 0;
  int n_waiting   = 0;

  assign fail_count     = n_fail;
  assign words_waiting  = n_waiting;
  assign words_checked  = n_checked;
  assign overflow_seen  = n_overflow;
  assign unmatched_seen = n_unmatched;

  // digits and letters go straight through
  function automatic bit is_operand(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // precedence, anything that is not an arithmetic operator ranks lowest
  function automatic int op_rank(logic [7:0] c);
    if (c == itp_pkg::CH_POW) return 3;
    if (c == itp_pkg::CH_MUL || c == itp_pkg::CH_DIV) return 2;
    if (c == itp_pkg::CH_ADD || c == itp_pkg::CH_SUB) return 1;
    return -1;
  endfunction

  function automatic pf_word_t pf_word(logic [7:0] c, itp_pkg::status_t s);
    pf_word_t w;
    w.out_char = c;
    w.run_last = 1'b0;
    w.status   = s;
    return w;
  endfunction

  // push onto the predicted stack, zero when it is already full
  function automatic bit stack_push(logic [7:0] c);
    if (stk_n >= DEPTH) return 1'b0;
    op_stk[stk_n] = c;
    stk_n++;
    return 1'b1;
  endfunction

  // work out every postfix word that one infix character causes
  task automatic convert_char(input logic [7:0] c, input logic last);
    pf_word_t   run [$];
    pf_word_t   tail;
    logic [7:0] top_ch;
    int         own;
    int         top_rank;
    int         i;
    bit         found;
    bit         right_assoc;

    if (is_operand(c)) begin
      run.push_back(pf_word(c, itp_pkg::ST_OK));
    end else if (c == itp_pkg::CH_OPEN) begin
      if (!stack_push(c)) run.push_back(pf_word(c, itp_pkg::ST_OVERFLOW));
    end else if (c == itp_pkg::CH_CLOSE) begin
      found = 1'b0;
      for (i = 0; i < stk_n; i++) begin
        if (op_stk[i] == itp_pkg::CH_OPEN) found = 1'b1;
      end
      if (!found) begin
        run.push_back(pf_word(c, itp_pkg::ST_UNMATCHED));
      end else begin
        while (stk_n > 0 && op_stk[stk_n - 1] != itp_pkg::CH_OPEN) begin
          stk_n--;
          run.push_back(pf_word(op_stk[stk_n], itp_pkg::ST_OK));
        end
        // drop the matching open bracket
        if (stk_n > 0) stk_n--;
      end
    end else begin
      own         = op_rank(c);
      right_assoc = (c == itp_pkg::CH_POW);
      while (stk_n > 0) begin
        top_ch = op_stk[stk_n - 1];
        if (top_ch == itp_pkg::CH_OPEN) break;
        top_rank = op_rank(top_ch);
        if (right_assoc ? (top_rank <= own) : (top_rank < own)) break;
        stk_n--;
        run.push_back(pf_word(top_ch, itp_pkg::ST_OK));
      end
      if (!stack_push(c)) run.push_back(pf_word(c, itp_pkg::ST_OVERFLOW));
    end

    // end of expression empties the stack
    if (last) begin
      while (stk_n > 0) begin
        stk_n--;
        run.push_back(pf_word(op_stk[stk_n], itp_pkg::ST_OK));
      end
    end

    if (run.size() > 0) begin
      tail = run.pop_back();
      tail.run_last = 1'b1;
      run.push_back(tail);
    end
    foreach (run[k]) postfix_due.push_back(run[k]);
  endtask

  // watch both channels at each rising edge
  always @(posedge clk) begin
    pf_word_t want;
    if (rst) begin
      stk_n = 0;
      postfix_due.delete();
    end else begin
      if (expr.valid && expr.ready) convert_char(expr.ch, expr.expr_end);
      if (postfix.valid && postfix.ready) begin
        if (postfix_due.size() == 0) begin
          $error("unexpected postfix word: out_char 0x%02h run_last %0b status %0d",
                 postfix.out_char, postfix.run_last, postfix.status);
          n_fail++;
        end else begin
          want = postfix_due.pop_front();
          n_checked++;
          if (postfix.out_char !== want.out_char) begin
            $error("out_char: expected 0x%02h, got 0x%02h", want.out_char, postfix.out_char);
            n_fail++;
          end
          if (postfix.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, postfix.run_last);
            n_fail++;
          end
          if (postfix.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, postfix.status);
            n_fail++;
          end
          if (want.status == itp_pkg::ST_OVERFLOW) n_overflow++;
          if (want.status == itp_pkg::ST_UNMATCHED) n_unmatched++;
        end
      end
    end
    n_waiting = postfix_due.size();
  end

endmodule

### tb/tb_infix_to_postfix_converter_top.sv
`timescale 1ns / 1ps
// testbench top for the infix to postfix converter: clock, reset, stimulus and verdict
module tb_infix_to_postfix_converter_top;

  localparam int DEPTH      = itp_pkg::STACK_DEPTH_DEF;
  localparam int ITEMS      = 310;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 100;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_LONG_STALL, RX_TOGGLE} rx_mode_t;
  typedef enum int {SEQ_WELL, SEQ_NOISE, SEQ_BROKEN, SEQ_DEEP} seq_kind_t;

  logic clk = 1'b0;
  logic rst;

  itp_expr_if    expr_ch ();
  itp_postfix_if post_ch ();

  int fail_count;
  int words_waiting;
  int words_checked;
  int overflow_seen;
  int unmatched_seen;

  int chars_sent = 0;
  int burst_left = 0;
  bit steady     = 1'b0;
  int idle_cycles = 0;
  logic [7:0] expr_buf [$];

  infix_to_postfix_converter_top #(.STACK_DEPTH(DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .expr    (expr_ch),
    .postfix (post_ch)
  );

  itp_postfix_checker #(.DEPTH(DEPTH)) u_chk (
    .clk            (clk),
    .rst            (rst),
    .expr           (expr_ch),
    .postfix        (post_ch),
    .fail_count     (fail_count),
    .words_waiting  (words_waiting),
    .words_checked  (words_checked),
    .overflow_seen  (overflow_seen),
    .unmatched_seen (unmatched_seen)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, switching between patterns
  rx_mode_t rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       stall_left = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   post_ch.ready <= 1'b1;
      RX_RANDOM: post_ch.ready <= ($urandom_range(0, 9) < 7);
      RX_LONG_STALL: begin
        if (stall_left > 0) begin
          post_ch.ready <= 1'b0;
          stall_left    <= stall_left - 1;
        end else begin
          post_ch.ready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 20);
        end
      end
      default:   post_ch.ready <= ~post_ch.ready;
    endcase
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (expr_ch.valid && expr_ch.ready) || (post_ch.valid && post_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // one infix word, with a random gap ahead of each burst
  task automatic send_word(input logic [7:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        expr_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    expr_ch.valid    <= 1'b1;
    expr_ch.ch       <= c;
    expr_ch.expr_end <= last;
    @(posedge clk);
    while (!expr_ch.ready) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) send_word(s[i], last && (i == s.len() - 1));
  endtask

  // hold the sender off until every predicted word has come out
  task automatic wait_drained();
    expr_ch.valid <= 1'b0;
    @(negedge clk);
    while (words_waiting != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return "0" + 8'($urandom_range(0, 9));
      1:       return "A" + 8'($urandom_range(0, 25));
      default: return "a" + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 4))
      0:       return itp_pkg::CH_POW;
      1:       return itp_pkg::CH_MUL;
      2:       return itp_pkg::CH_DIV;
      3:       return itp_pkg::CH_ADD;
      default: return itp_pkg::CH_SUB;
    endcase
  endfunction

  // well-formed expression with random operands, operators and brackets
  task automatic build_expr();
    int terms;
    int open_n;
    expr_buf.delete();
    open_n = 0;
    terms  = $urandom_range(1, 8);
    for (int i = 0; i < terms; i++) begin
      while (open_n < 6 && $urandom_range(0, 3) == 0) begin
        expr_buf.push_back(itp_pkg::CH_OPEN);
        open_n++;
      end
      expr_buf.push_back(rand_operand());
      while (open_n > 0 && $urandom_range(0, 2) == 0) begin
        expr_buf.push_back(itp_pkg::CH_CLOSE);
        open_n--;
      end
      if (i != terms - 1) expr_buf.push_back(rand_operator());
    end
    while (open_n > 0) begin
      expr_buf.push_back(itp_pkg::CH_CLOSE);
      open_n--;
    end
  endtask

  task automatic send_buf(input logic last);
    foreach (expr_buf[i]) send_word(expr_buf[i], last && (i == expr_buf.size() - 1));
  endtask

  // fill the stack with open brackets, overflow it twice, then close and flush
  task automatic send_deep();
    for (int i = 0; i <= DEPTH; i++) send_word(itp_pkg::CH_OPEN, 1'b0);
    send_word(itp_pkg::CH_ADD, 1'b0);
    send_word(rand_operand(), 1'b0);
    send_word(itp_pkg::CH_CLOSE, 1'b1);
  endtask

  // stimulus
  initial begin
    seq_kind_t kind;
    bit        paused_mid;
    int        pick;
    rst              = 1'b1;
    expr_ch.valid    = 1'b0;
    expr_ch.ch       = 8'h00;
    expr_ch.expr_end = 1'b0;
    post_ch.ready    = 1'b0;
    paused_mid       = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // precedence, right-assoc power, brackets, an unmatched close
    send_text("a+B*7^z^Z-(9/0))", 1'b0);
    // unranked bytes pop everything down to a bracket
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(" ", 1'b1);
    // open bracket left at the end comes out in the flush
    send_text("(x", 1'b1);
    wait_drained();

    send_deep();

    // random part
    while (chars_sent < ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      pick   = $urandom_range(0, 99);
      if (pick < 68)      kind = SEQ_WELL;
      else if (pick < 84) kind = SEQ_NOISE;
      else if (pick < 98) kind = SEQ_BROKEN;
      else                kind = SEQ_DEEP;
      if (!paused_mid && chars_sent >= ITEMS / 2) begin
        paused_mid = 1'b1;
        wait_drained();
        kind = SEQ_DEEP;
      end
      case (kind)
        SEQ_WELL: begin
          build_expr();
          send_buf(1'b1);
        end
        SEQ_NOISE: begin
          repeat ($urandom_range(1, 6))
            send_word(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
        end
        SEQ_BROKEN: begin
          build_expr();
          case ($urandom_range(0, 2))
            0: expr_buf[$urandom_range(0, expr_buf.size() - 1)] = 8'($urandom_range(0, 255));
            1: expr_buf.insert($urandom_range(0, expr_buf.size()), itp_pkg::CH_CLOSE);
            default: expr_buf.push_front(itp_pkg::CH_OPEN);
          endcase
          send_buf($urandom_range(0, 2) != 0);
        end
        default: send_deep();
      endcase
    end

    // drain and let the block settle
    wait_drained();
    repeat (SETTLE) @(negedge clk);

    $display("sent %0d infix characters, checked %0d postfix words", chars_sent, words_checked);
    $display("dropped on full stack: %0d, dropped unmatched brackets: %0d",
             overflow_seen, unmatched_seen);
    if (fail_count == 0 && words_waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
